/* sv/cls_pkg.sv */
// types and constants shared by the compacting list store
// no dependencies
`default_nettype none

package cls_pkg;

  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int FILL_W   = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_DUMP   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DEL  = 2'd1,
    S_DUMP = 2'd2
  } state_e;

  typedef struct packed {
    op_e                       op;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic [INDEX_W-1:0]        position;
    logic [FILL_W-1:0]         fill;
    logic                      last;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/cls_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cls_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/compacting_list_store.sv */
// compacting list store: ordered list of signed words with shift-down delete
// depends on cls_pkg and cls_ram
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// clear, append, update and error cases give one item.
// delete moves the later entries down: one ram read and write per moved entry.
// dump gives one item per cycle from the ram read port while the output is not stalled, fill items in all.
// reset empties the list at once; entries need no clearing pass.
// a stalled output holds the current item and freezes dump reads.
`default_nettype none

module compacting_list_store
  import cls_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, res;
  logic            out_load, out_free, in_acc;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  logic [FILL_W-1:0] idx7, cnt7, ptr7;
  logic            is_empty, is_full, bad_index, has_next, del_more, dump_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx7      = FILL_W'(in_item_i.index);
  assign cnt7      = FILL_W'(count_q);
  assign ptr7      = FILL_W'(ptr_q);
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CW'(CAPACITY));
  assign bad_index = (idx7 >= cnt7);
  assign has_next  = ((idx7 + FILL_W'(1)) < cnt7);
  // count is already decremented while entries move down
  assign del_more  = ((ptr7 + FILL_W'(1)) < cnt7);
  assign dump_last = ((ptr7 + FILL_W'(1)) == cnt7);

  cls_ram #(
    .Width (DATA_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item_i.op)
            OP_DELETE: begin
              if (!is_empty && !bad_index && has_next) begin
                state_d = S_DEL;
              end
            end
            OP_DUMP: begin
              if (!is_empty) begin
                state_d = S_DUMP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DEL: begin
        if (!del_more) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free && dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_d  = count_q;
    ptr_d    = ptr_q;
    we       = 1'b0;
    waddr    = ptr_q;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = '0;
    res      = '0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load   = 1'b1;
          res.status = ST_OK;
          case (in_item_i.op)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = AW'(count_q);
                wdata   = in_item_i.value;
                count_d = count_q + CW'(1);
              end
            end
            OP_UPDATE: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else if (bad_index) begin
                res.status = ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = AW'(in_item_i.index);
                wdata = in_item_i.value;
              end
            end
            OP_DELETE: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else if (bad_index) begin
                res.status = ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                ptr_d   = AW'(in_item_i.index);
                if (has_next) begin
                  re    = 1'b1;
                  raddr = AW'(idx7 + FILL_W'(1));
                end
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                out_load = 1'b0;
                re       = 1'b1;
                raddr    = '0;
                ptr_d    = '0;
              end
            end
            default: res.status = ST_OK;
          endcase
          res.fill = FILL_W'(count_d);
          res.last = 1'b1;
        end
      end
      S_DEL: begin
        // move entry ptr+1 (read last cycle) down to ptr, fetch ptr+2
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata;
        ptr_d = ptr_q + AW'(1);
        if (del_more) begin
          re    = 1'b1;
          raddr = AW'(ptr7 + FILL_W'(2));
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load     = 1'b1;
          res.status   = ST_OK;
          res.data     = rdata;
          res.position = INDEX_W'(ptr_q);
          res.fill     = FILL_W'(count_q);
          res.last     = dump_last;
          if (!dump_last) begin
            re    = 1'b1;
            raddr = AW'(ptr7 + FILL_W'(1));
            ptr_d = ptr_q + AW'(1);
          end
        end
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we && re |-> waddr != raddr)
    else $error("ram read and write hit the same entry");

  a_del_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEL |-> !out_load)
    else $error("result produced while entries move");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res.status != ST_OK |-> res.last)
    else $error("error result not flagged last");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP && out_load && res.last |=> state_q == S_IDLE)
    else $error("dump continues after last item");
`endif

endmodule

`default_nettype wire
